### design/pixel_window_palette_ypbpr_defines.svh
// Assertion macros shared by the pixel window palette block.
`ifndef PIXEL_WINDOW_PALETTE_YPBPR_DEFINES_SVH
`define PIXEL_WINDOW_PALETTE_YPBPR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PWP_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PWP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/pwp_pkg.sv
// Shared types, constants and functions of the pixel window palette block.
`default_nettype none

package pwp_pkg;

    localparam int COORD_W  = 9;
    localparam int SKIP_W   = 8;
    localparam int FRAME_W  = 32;
    localparam int CI_W     = 4;
    localparam int BRIGHT_W = 16;
    localparam int SAT_W    = 17;
    localparam int CFG_W    = 17;
    localparam int CFG_IDX_W = 3;
    localparam int CHAN_W   = 8;

    // Palette entry widths: Y is unsigned Q14 up to 1.0, Pb/Pr signed Q14.
    localparam int PAL_Y_W = 15;
    localparam int PAL_C_W = 16;

    // Datapath widths.
    localparam int PROD_W  = SAT_W + PAL_C_W;       // sat * chroma
    localparam int UV_W    = PROD_W + 1;            // sum of two products
    localparam int LUMA_W  = BRIGHT_W + PAL_Y_W;    // brightness * Y
    localparam int COEF_W  = 18;
    localparam int CPROD_W = UV_W + COEF_W - 1;     // coefficient * chroma
    localparam int SUM_W   = 52;                    // channel sum, Q45
    localparam int LUMA_SH = 17;

    // Conversion coefficients, Q16.
    localparam logic signed [COEF_W-1:0] COEF_RV = 18'sd91881;
    localparam logic signed [COEF_W-1:0] COEF_GU = 18'sd28488;
    localparam logic signed [COEF_W-1:0] COEF_GV = 18'sd46802;
    localparam logic signed [COEF_W-1:0] COEF_BU = 18'sd116130;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic MODE_PIXEL     = 1'b0;
    localparam logic MODE_FRAME_END = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_X   = 3'd0,
        CFG_WINDOW_Y   = 3'd1,
        CFG_WINDOW_W   = 3'd2,
        CFG_WINDOW_H   = 3'd3,
        CFG_FRAME_SKIP = 3'd4,
        CFG_BRIGHTNESS = 3'd5,
        CFG_SAT_COS    = 3'd6,
        CFG_SAT_SIN    = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [COORD_W-1:0]         window_x;
        logic [COORD_W-1:0]         window_y;
        logic [COORD_W-1:0]         window_w;
        logic [COORD_W-1:0]         window_h;
        logic [SKIP_W-1:0]          frame_skip;
        logic [BRIGHT_W-1:0]        brightness;
        logic signed [SAT_W-1:0]    sat_cos;
        logic signed [SAT_W-1:0]    sat_sin;
    } t_cfg;

    // One classified transaction handed from front to back.
    typedef struct packed {
        logic                 is_frame_end;
        logic [COORD_W-1:0]   row;
        logic [COORD_W-1:0]   col;
        logic [CI_W-1:0]      color_index;
        logic [FRAME_W-1:0]   frame_number;
    } t_job;

    typedef struct packed {
        logic [PAL_Y_W-1:0]         y;
        logic signed [PAL_C_W-1:0]  pb;
        logic signed [PAL_C_W-1:0]  pr;
    } t_pal;

    function automatic t_pal pal_lookup(input logic [CI_W-1:0] ci);
        t_pal p;
        case (ci)
            4'd0:    p = '{15'd0,     16'sd0,      16'sd0};
            4'd1:    p = '{15'd16384, 16'sd0,      16'sd0};
            4'd2:    p = '{15'd4096,  -16'sd6270,  16'sd15137};
            4'd3:    p = '{15'd12288, 16'sd6270,   -16'sd15137};
            4'd4:    p = '{15'd8192,  16'sd11585,  16'sd11585};
            4'd5:    p = '{15'd8192,  -16'sd11585, -16'sd11585};
            4'd6:    p = '{15'd4096,  16'sd16384,  16'sd0};
            4'd7:    p = '{15'd12288, -16'sd16384, 16'sd0};
            4'd8:    p = '{15'd8192,  -16'sd11585, 16'sd11585};
            4'd9:    p = '{15'd12288, -16'sd11585, 16'sd11585};
            4'd10:   p = '{15'd8192,  -16'sd6270,  16'sd15137};
            4'd11:   p = '{15'd16384, 16'sd6270,   -16'sd15137};
            4'd12:   p = '{15'd12288, 16'sd11585,  16'sd11585};
            4'd13:   p = '{15'd12288, -16'sd11585, -16'sd11585};
            4'd14:   p = '{15'd8192,  16'sd16384,  16'sd0};
            4'd15:   p = '{15'd16384, -16'sd16384, 16'sd0};
            default: p = '{15'd0,     16'sd0,      16'sd0};
        endcase
        return p;
    endfunction

    // Q45 channel to 8 bits: negative gives 0, 1.0 or more gives 255.
    function automatic logic [CHAN_W-1:0] to_channel(input logic signed [SUM_W-1:0] t);
        logic [CHAN_W-1:0] c;
        if (t[SUM_W-1]) begin
            c = '0;
        end else if (|t[SUM_W-2:45]) begin
            c = '1;
        end else begin
            c = t[44:37];
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### design/pwp_in_if.sv
// Input channel: pixel or frame-end transactions.
`default_nettype none

interface pwp_in_if;
    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic [pwp_pkg::COORD_W-1:0]   line;
    logic [pwp_pkg::COORD_W-1:0]   column;
    logic [pwp_pkg::CI_W-1:0]      color_index;

    modport source (output valid, mode, line, column, color_index, input ready);
    modport sink   (input valid, mode, line, column, color_index, output ready);
endinterface

`default_nettype wire

### design/pwp_out_if.sv
// Output channel: RGB pixel or frame-end transactions.
`default_nettype none

interface pwp_out_if;
    logic                          valid;
    logic                          ready;
    logic                          is_frame_end;
    logic [pwp_pkg::COORD_W-1:0]   out_row;
    logic [pwp_pkg::COORD_W-1:0]   out_col;
    logic [pwp_pkg::CHAN_W-1:0]    red;
    logic [pwp_pkg::CHAN_W-1:0]    green;
    logic [pwp_pkg::CHAN_W-1:0]    blue;
    logic [pwp_pkg::FRAME_W-1:0]   frame_number;

    modport source (output valid, is_frame_end, out_row, out_col, red, green, blue,
                    frame_number, input ready);
    modport sink   (input valid, is_frame_end, out_row, out_col, red, green, blue,
                    frame_number, output ready);
endinterface

`default_nettype wire

### design/pwp_front.sv
// Front end: accepts transactions, applies crop window and frame skipping.
`default_nettype none

module pwp_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire pwp_pkg::t_cfg  i_cfg,
    input  wire logic           i_skip_clr,
    pwp_in_if.sink              i_in,
    input  wire logic           i_full,
    output logic                o_push,
    output pwp_pkg::t_job       o_job
);

    logic [pwp_pkg::SKIP_W-1:0]   r_skip_left, n_skip_left;
    logic [pwp_pkg::FRAME_W-1:0]  r_frame_count, n_frame_count;

    logic                          accept;
    logic [pwp_pkg::COORD_W:0]     line_end;
    logic [pwp_pkg::COORD_W-1:0]   row_off;
    logic [pwp_pkg::COORD_W-1:0]   col_off;
    logic                          in_y;
    logic                          in_x;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && i_in.ready;

    // Window bounds without wrap: the end may pass the raster edge.
    assign line_end = {1'b0, i_cfg.window_y} + {1'b0, i_cfg.window_h};
    assign row_off  = i_in.line - i_cfg.window_y;
    assign col_off  = i_in.column - i_cfg.window_x;
    assign in_y     = (i_in.line >= i_cfg.window_y) && ({1'b0, i_in.line} < line_end);
    assign in_x     = (i_in.column >= i_cfg.window_x) && (col_off < i_cfg.window_w);

    always_comb begin
        n_skip_left   = r_skip_left;
        n_frame_count = r_frame_count;
        o_push        = 1'b0;
        o_job         = '0;
        if (accept) begin
            if (i_in.mode == pwp_pkg::MODE_FRAME_END) begin
                if (r_skip_left != '0) begin
                    // drop this frame
                    n_skip_left = r_skip_left - 1'b1;
                end else begin
                    n_skip_left        = i_cfg.frame_skip;
                    n_frame_count      = r_frame_count + 1'b1;
                    o_push             = 1'b1;
                    o_job.is_frame_end = 1'b1;
                    o_job.frame_number = r_frame_count + 1'b1;
                end
            end else if (r_skip_left == '0 && in_y && in_x) begin
                o_push             = 1'b1;
                o_job.row          = row_off;
                o_job.col          = col_off;
                o_job.color_index  = i_in.color_index;
                o_job.frame_number = r_frame_count;
            end
        end
        if (i_skip_clr) begin
            n_skip_left = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip_left   <= '0;
            r_frame_count <= '0;
        end else begin
            r_skip_left   <= n_skip_left;
            r_frame_count <= n_frame_count;
        end
    end

endmodule

`default_nettype wire

### design/pwp_queue.sv
// Two-entry queue decoupling the front end from the color pipeline.
`default_nettype none

module pwp_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire pwp_pkg::t_job  i_job,
    output logic                o_full,
    output logic                o_valid,
    input  wire logic           i_pop,
    output pwp_pkg::t_job       o_job
);

    pwp_pkg::t_job                  r_mem [pwp_pkg::QUEUE_DEPTH];
    logic [pwp_pkg::QUEUE_AW-1:0]   r_wr, n_wr;
    logic [pwp_pkg::QUEUE_AW-1:0]   r_rd, n_rd;
    logic [pwp_pkg::QUEUE_CW-1:0]   r_count, n_count;
    logic                           do_push;
    logic                           do_pop;

    assign o_full  = (r_count == pwp_pkg::QUEUE_CW'(pwp_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == pwp_pkg::QUEUE_AW'(pwp_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == pwp_pkg::QUEUE_AW'(pwp_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

### design/pwp_back.sv
// Back end: palette lookup, luma gain, chroma rotation and RGB conversion.
`default_nettype none

module pwp_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire pwp_pkg::t_cfg  i_cfg,
    input  wire logic           i_valid,
    input  wire pwp_pkg::t_job  i_job,
    output logic                o_pop,
    pwp_out_if.source           o_out
);

    localparam int PW = pwp_pkg::PROD_W;
    localparam int UW = pwp_pkg::UV_W;
    localparam int LW = pwp_pkg::LUMA_W;
    localparam int CW = pwp_pkg::CPROD_W;
    localparam int SW = pwp_pkg::SUM_W;

    logic adv;

    // stage 1: palette entry
    logic                r_v1;
    pwp_pkg::t_job       r_job1;
    pwp_pkg::t_pal       r_pal1;

    // stage 2: raw products
    logic                r_v2;
    pwp_pkg::t_job       r_job2;
    logic signed [PW-1:0] r_cpb2, r_spr2, r_cpr2, r_spb2;
    logic [LW-1:0]       r_luma2;

    // stage 3: rotated chroma
    logic                r_v3;
    pwp_pkg::t_job       r_job3;
    logic signed [UW-1:0] r_u3, r_v3c;
    logic [LW-1:0]       r_luma3;

    // stage 4: coefficient products
    logic                r_v4;
    pwp_pkg::t_job       r_job4;
    logic signed [CW-1:0] r_rv4, r_gu4, r_gv4, r_bu4;
    logic [LW-1:0]       r_luma4;

    // output stage
    logic                          r_v5;
    logic                          r_fe5;
    logic [pwp_pkg::COORD_W-1:0]   r_row5, r_col5;
    logic [pwp_pkg::CHAN_W-1:0]    r_red5, r_green5, r_blue5;
    logic [pwp_pkg::FRAME_W-1:0]   r_frame5;

    logic signed [SW-1:0] lum_s, sum_r, sum_g, sum_b;

    // whole pipeline holds while a finished result waits
    assign adv   = !r_v5 || o_out.ready;
    assign o_pop = adv && i_valid;

    assign lum_s = signed'(SW'({r_luma4, {pwp_pkg::LUMA_SH{1'b0}}}));
    assign sum_r = lum_s + SW'(r_rv4);
    assign sum_g = lum_s - SW'(r_gu4) - SW'(r_gv4);
    assign sum_b = lum_s + SW'(r_bu4);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_job1 <= i_job;
            r_pal1 <= pwp_pkg::pal_lookup(i_job.color_index);

            r_job2  <= r_job1;
            r_cpb2  <= PW'(i_cfg.sat_cos) * PW'(r_pal1.pb);
            r_spr2  <= PW'(i_cfg.sat_sin) * PW'(r_pal1.pr);
            r_cpr2  <= PW'(i_cfg.sat_cos) * PW'(r_pal1.pr);
            r_spb2  <= PW'(i_cfg.sat_sin) * PW'(r_pal1.pb);
            r_luma2 <= LW'(i_cfg.brightness) * LW'(r_pal1.y);

            r_job3  <= r_job2;
            r_u3    <= UW'(r_cpb2) + UW'(r_spr2);
            r_v3c   <= UW'(r_cpr2) - UW'(r_spb2);
            r_luma3 <= r_luma2;

            r_job4  <= r_job3;
            r_rv4   <= CW'(pwp_pkg::COEF_RV) * CW'(r_v3c);
            r_gu4   <= CW'(pwp_pkg::COEF_GU) * CW'(r_u3);
            r_gv4   <= CW'(pwp_pkg::COEF_GV) * CW'(r_v3c);
            r_bu4   <= CW'(pwp_pkg::COEF_BU) * CW'(r_u3);
            r_luma4 <= r_luma3;

            r_fe5    <= r_job4.is_frame_end;
            r_row5   <= r_job4.row;
            r_col5   <= r_job4.col;
            r_frame5 <= r_job4.frame_number;
            if (r_job4.is_frame_end) begin
                r_red5   <= '0;
                r_green5 <= '0;
                r_blue5  <= '0;
            end else begin
                r_red5   <= pwp_pkg::to_channel(sum_r);
                r_green5 <= pwp_pkg::to_channel(sum_g);
                r_blue5  <= pwp_pkg::to_channel(sum_b);
            end
        end
    end

    assign o_out.valid        = r_v5;
    assign o_out.is_frame_end = r_fe5;
    assign o_out.out_row      = r_row5;
    assign o_out.out_col      = r_col5;
    assign o_out.red          = r_red5;
    assign o_out.green        = r_green5;
    assign o_out.blue         = r_blue5;
    assign o_out.frame_number = r_frame5;

endmodule

`default_nettype wire

### design/pixel_window_palette_ypbpr.sv
// Crop window, YPbPr palette and RGB conversion with frame skipping.
// Throughput: one transaction per cycle while the output accepts results; a two-entry
// queue decouples input from output. An accepted transaction passes through the queue,
// then the lookup, product, chroma, coefficient and clamp stages of the back end.
// Reset (synchronous, active low) restores register defaults, clears the skip
// and frame counters and empties the queue and pipeline.
`default_nettype none
`include "pixel_window_palette_ypbpr_defines.svh"

module pixel_window_palette_ypbpr (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [pwp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [pwp_pkg::CFG_W-1:0]       i_cfg_data,
    pwp_in_if.sink                               i_in,
    pwp_out_if.source                            o_out
);

    pwp_pkg::t_cfg  r_cfg;
    logic           skip_clr;
    logic           q_push, q_full, q_valid, q_pop;
    pwp_pkg::t_job  push_job, head_job;

    assign skip_clr = i_cfg_we &&
                      (pwp_pkg::t_cfg_idx'(i_cfg_idx) == pwp_pkg::CFG_FRAME_SKIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_x   <= '0;
            r_cfg.window_y   <= '0;
            r_cfg.window_w   <= 9'd260;
            r_cfg.window_h   <= 9'd261;
            r_cfg.frame_skip <= '0;
            r_cfg.brightness <= 16'd16384;
            r_cfg.sat_cos    <= 17'sd16384;
            r_cfg.sat_sin    <= '0;
        end else if (i_cfg_we) begin
            case (pwp_pkg::t_cfg_idx'(i_cfg_idx))
                pwp_pkg::CFG_WINDOW_X:   r_cfg.window_x   <= i_cfg_data[pwp_pkg::COORD_W-1:0];
                pwp_pkg::CFG_WINDOW_Y:   r_cfg.window_y   <= i_cfg_data[pwp_pkg::COORD_W-1:0];
                pwp_pkg::CFG_WINDOW_W:   r_cfg.window_w   <= i_cfg_data[pwp_pkg::COORD_W-1:0];
                pwp_pkg::CFG_WINDOW_H:   r_cfg.window_h   <= i_cfg_data[pwp_pkg::COORD_W-1:0];
                pwp_pkg::CFG_FRAME_SKIP: r_cfg.frame_skip <= i_cfg_data[pwp_pkg::SKIP_W-1:0];
                pwp_pkg::CFG_BRIGHTNESS: r_cfg.brightness <= i_cfg_data[pwp_pkg::BRIGHT_W-1:0];
                pwp_pkg::CFG_SAT_COS:    r_cfg.sat_cos    <= signed'(i_cfg_data);
                pwp_pkg::CFG_SAT_SIN:    r_cfg.sat_sin    <= signed'(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    pwp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_skip_clr (skip_clr),
        .i_in       (i_in),
        .i_full     (q_full),
        .o_push     (q_push),
        .o_job      (push_job)
    );

    pwp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_job   (head_job)
    );

    pwp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (q_valid),
        .i_job   (head_job),
        .o_pop   (q_pop),
        .o_out   (o_out)
    );

    `PWP_ASSERT_IMPLIES(a_frame_end_black, i_clk, i_rst_n, o_out.valid && o_out.is_frame_end, o_out.red == 8'd0 && o_out.green == 8'd0 && o_out.blue == 8'd0, "frame end result carries color")
    `PWP_ASSERT_IMPLIES(a_pixel_in_window, i_clk, i_rst_n, o_out.valid && !o_out.is_frame_end, o_out.out_row < r_cfg.window_h && o_out.out_col < r_cfg.window_w, "pixel result outside crop window")
    `PWP_ASSERT_IMPLIES(a_quiet_after_reset, i_clk, i_rst_n, $rose(i_rst_n), !o_out.valid && q_valid == 1'b0, "result pending right after reset")
    `PWP_ASSERT_NEXT(a_queue_drains, i_clk, i_rst_n, q_full && q_pop, !q_full || q_push, "queue stays full after pop without push")

endmodule

`default_nettype wire
